[src/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg - shared types and constants of the set-associative lookup block
// Geometry, field widths, configuration and outcome codes, and the structs
// passed between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  // Geometry
  localparam int MaxSetBits = 6;
  localparam int MaxWays    = 8;
  localparam int AddrWidth  = 64;

  localparam int AddrW      = 64;
  localparam int TagWidth   = 62;
  localparam int StampWidth = 64;
  localparam int TallyWidth = 32;

  localparam int NumSets  = 1 << MaxSetBits;
  localparam int SetW     = MaxSetBits;
  localparam int SbW      = $clog2(MaxSetBits + 1);
  localparam int WayIdxW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int WayOutW  = 3;
  localparam int OutcomeW = 2;

  localparam logic [AddrW-1:0] AddrMask =
    (AddrWidth >= AddrW) ? {AddrW{1'b1}} : ((AddrW'(1) << AddrWidth) - AddrW'(1));

  // Configuration port
  localparam int CfgSetW  = 3;
  localparam int CfgOffW  = 6;
  localparam int CfgWaysW = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CfgSetIndexBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffsetBits   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgActiveWays   = 2'd2;

  // Outcome codes
  localparam logic [OutcomeW-1:0] OutHit   = 2'd0;
  localparam logic [OutcomeW-1:0] OutFill  = 2'd1;
  localparam logic [OutcomeW-1:0] OutEvict = 2'd2;

  typedef struct packed {
    logic [CfgSetW-1:0]  set_index_bits;
    logic [CfgOffW-1:0]  offset_bits;
    logic [CfgWaysW-1:0] active_ways;
  } cfg_t;

  typedef struct packed {
    logic [SetW-1:0]     set_idx;
    logic [TagWidth-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [OutcomeW-1:0]   outcome;
    logic [WayOutW-1:0]    way_used;
    logic [TallyWidth-1:0] hits_total;
    logic [TallyWidth-1:0] misses_total;
    logic [TallyWidth-1:0] evictions_total;
  } res_t;

  typedef struct packed {
    logic [MaxWays-1:0]                 valid;
    logic [MaxWays-1:0][TagWidth-1:0]   tag;
    logic [MaxWays-1:0][StampWidth-1:0] stamp;
  } row_t;

endpackage

`default_nettype wire

[src/slc_front.sv]
// ----------------------------------------------------------------------------
// slc_front - address split and request queue
// Splits each accepted address into set index and tag and holds the requests
// in a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front import slc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             clearing_i,
  input  wire logic             push_i,
  input  wire logic [AddrW-1:0] address_i,
  output logic                  full_o,
  output req_t                  req_o,
  output logic                  req_valid_o,
  input  wire logic             req_pop_i
);

  localparam int QDepth = 2;

  logic [AddrW-1:0]   addr_m;
  logic [AddrW-1:0]   shifted;
  logic [AddrW-1:0]   tag_full;
  logic [SbW-1:0]     sbits_eff;
  logic [SetW:0]      set_lim;
  logic [SetW-1:0]    set_mask;
  req_t               req_new;

  req_t               queue_q [QDepth];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         count_q;
  logic               push_ok;

  always_comb begin
    addr_m    = address_i & AddrMask;
    shifted   = addr_m >> cfg_i.offset_bits;
    sbits_eff = (int'(cfg_i.set_index_bits) > MaxSetBits) ? SbW'(MaxSetBits)
                                                          : SbW'(cfg_i.set_index_bits);
    set_lim   = {{SetW{1'b0}}, 1'b1} << sbits_eff;
    set_mask  = SetW'(set_lim - {{SetW{1'b0}}, 1'b1});
    tag_full  = shifted >> sbits_eff;
    req_new.set_idx = shifted[SetW-1:0] & set_mask;
    req_new.tag     = tag_full[TagWidth-1:0];
  end

  assign full_o      = clearing_i || (count_q == 2'(QDepth));
  assign push_ok     = push_i && !full_o;
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_ok) begin
        queue_q[wr_ptr_q] <= req_new;
        wr_ptr_q          <= ~wr_ptr_q;
      end
      if (req_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_ok) - 2'(req_pop_i);
    end
  end

endmodule

`default_nettype wire

[src/slc_back.sv]
// ----------------------------------------------------------------------------
// slc_back - tag store, LRU choice and result register
// Reads one set row per request, decides hit, fill or eviction, writes the
// row back and loads the result register. Clears all valid bits after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_back import slc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire req_t req_i,
  input  wire logic req_valid_i,
  output logic      req_pop_o,
  output logic      clearing_o,
  output res_t      res_o,
  output logic      res_valid_o,
  input  wire logic res_pop_i
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL} state_e;

  state_e                 state_q;
  logic [SetW-1:0]        clr_cnt_q;
  req_t                   cur_q;
  logic [StampWidth-1:0]  stamp_q;
  logic [TallyWidth-1:0]  hits_q, misses_q, evicts_q;
  logic [OutcomeW-1:0]    outcome_q;
  logic [WayOutW-1:0]     way_q;
  logic                   out_valid_q;

  row_t                   mem_q [NumSets];
  row_t                   rd_row_q;

  logic                   rd_en, wr_en, eval_fire;
  logic [SetW-1:0]        wr_set;
  row_t                   wr_row, upd_row;

  logic [CfgWaysW-1:0]    ways_eff;
  logic [MaxWays-1:0]     act, hit_vec, inv_vec, lru_vec;
  logic                   is_hit, is_fill;
  logic [WayIdxW-1:0]     way;
  logic [OutcomeW-1:0]    outcome_d;

  function automatic logic [WayIdxW-1:0] first_one(input logic [MaxWays-1:0] v);
    logic [WayIdxW-1:0] idx;
    logic               found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < MaxWays; i++) begin
      if (v[i] && !found) begin
        idx   = WayIdxW'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

  assign clearing_o  = (state_q == S_CLEAR);
  assign rd_en       = (state_q == S_IDLE) && req_valid_i;
  assign req_pop_o   = rd_en;
  assign eval_fire   = (state_q == S_EVAL) && (!out_valid_q || res_pop_i);
  assign res_valid_o = out_valid_q;

  assign res_o.outcome         = outcome_q;
  assign res_o.way_used        = way_q;
  assign res_o.hits_total      = hits_q;
  assign res_o.misses_total    = misses_q;
  assign res_o.evictions_total = evicts_q;

  // Per-way classification of the row that was read
  always_comb begin
    if (cfg_i.active_ways == '0) begin
      ways_eff = CfgWaysW'(1);
    end else if (int'(cfg_i.active_ways) > MaxWays) begin
      ways_eff = CfgWaysW'(MaxWays);
    end else begin
      ways_eff = cfg_i.active_ways;
    end
    for (int w = 0; w < MaxWays; w++) begin
      act[w]     = (w < int'(ways_eff));
      hit_vec[w] = act[w] && rd_row_q.valid[w] && (rd_row_q.tag[w] == cur_q.tag);
      inv_vec[w] = act[w] && !rd_row_q.valid[w];
    end
    // A way is the LRU victim when its stamp is below every earlier way's
    // and not above any later way's, so the lowest way wins a tie.
    for (int w = 0; w < MaxWays; w++) begin
      lru_vec[w] = act[w];
      for (int v = 0; v < MaxWays; v++) begin
        if (act[v] && (v < w)) begin
          lru_vec[w] = lru_vec[w] && (rd_row_q.stamp[w] < rd_row_q.stamp[v]);
        end else if (act[v] && (v > w)) begin
          lru_vec[w] = lru_vec[w] && (rd_row_q.stamp[w] <= rd_row_q.stamp[v]);
        end
      end
    end

    is_hit  = |hit_vec;
    is_fill = !is_hit && (|inv_vec);
    if (is_hit) begin
      way       = first_one(hit_vec);
      outcome_d = OutHit;
    end else if (is_fill) begin
      way       = first_one(inv_vec);
      outcome_d = OutFill;
    end else begin
      way       = first_one(lru_vec);
      outcome_d = OutEvict;
    end

    upd_row            = rd_row_q;
    upd_row.valid[way] = 1'b1;
    upd_row.tag[way]   = cur_q.tag;
    upd_row.stamp[way] = stamp_q;

    wr_en  = clearing_o || eval_fire;
    wr_set = clearing_o ? clr_cnt_q : cur_q.set_idx;
    wr_row = clearing_o ? '0 : upd_row;
  end

  // Set memory: at most one row written and one row read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[req_i.set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      stamp_q     <= StampWidth'(1);
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces the one leaving in the same cycle.
      if (eval_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + SetW'(1);
          if (clr_cnt_q == SetW'(NumSets - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_en) begin
            cur_q   <= req_i;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (eval_fire) begin
            stamp_q     <= stamp_q + StampWidth'(1);
            outcome_q   <= outcome_d;
            way_q       <= WayOutW'(way);
            if (is_hit && (hits_q != '1)) begin
              hits_q <= hits_q + TallyWidth'(1);
            end
            if (!is_hit && (misses_q != '1)) begin
              misses_q <= misses_q + TallyWidth'(1);
            end
            if (!is_hit && !is_fill && (evicts_q != '1)) begin
              evicts_q <= evicts_q + TallyWidth'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // No request may be taken while the valid bits are still being cleared.
  a_no_read_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !req_pop_o)
    else $error("request taken during the clearing pass");

  // With every active way valid, exactly one way is chosen for eviction.
  a_one_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EVAL) && (inv_vec == '0)) |-> $onehot(lru_vec))
    else $error("LRU victim is not unique");

  // The stamp counter only moves when an access is completed.
  a_stamp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eval_fire |=> $stable(stamp_q))
    else $error("stamp counter changed without an access");

  // A completed access always leaves a result waiting.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire |=> (out_valid_q && ((outcome_q == OutHit) || (outcome_q == OutFill) ||
                                   (outcome_q == OutEvict))))
    else $error("completed access left no valid result");

endmodule

`default_nettype wire

[src/set_assoc_lru_cache_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup - tag store of a set-associative LRU cache
// Classifies each address as hit, fill or eviction and keeps running totals.
// ----------------------------------------------------------------------------
// Usage. Addresses enter through a queue-style port: an address is
// transferred at a rising edge where push is high and full is low. Results
// leave the same way: the oldest result sits on the result ports while empty
// is low and is transferred at an edge where pop is high. Each address gives
// exactly one result, in order. The configuration registers (set index bits,
// offset bits, active ways) are written through their own valid/ready
// channel, which is always ready; write them only while the block is idle.
// Flow. The front end splits the address and queues it (two entries). The
// back end reads the set row from the tag memory into a register, then
// compares, chooses the way, writes the row back and loads the result
// register; it takes no new address from the queue until that write-back
// is done, since each access reads and then writes the set memory.
// Reset. After reset the back end sweeps the 64 set rows, one per cycle,
// clearing all valid bits; full stays high for the whole sweep.
// Stalls. When pop is held low, one result waits in the output register,
// the back end holds its next access and the front queue fills, then full
// rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_lookup import slc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // address channel
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [AddrW-1:0]      address_i,
  // result channel
  output logic                       empty,
  input  wire logic                  pop,
  output logic [OutcomeW-1:0]        outcome_o,
  output logic [WayOutW-1:0]         way_used_o,
  output logic [TallyWidth-1:0]      hits_total_o,
  output logic [TallyWidth-1:0]      misses_total_o,
  output logic [TallyWidth-1:0]      evictions_total_o,
  // configuration channel
  input  wire logic                  valid,
  output logic                       ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i
);

  cfg_t cfg_q;
  req_t req;
  res_t res;
  logic req_valid;
  logic req_pop;
  logic clearing;
  logic res_valid;

  // The configuration channel never stalls; a write to an unused index is
  // accepted and dropped.
  assign ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_index_bits <= CfgSetW'(4);
      cfg_q.offset_bits    <= CfgOffW'(4);
      cfg_q.active_ways    <= CfgWaysW'(1);
    end else if (valid && ready) begin
      unique case (cfg_index_i)
        CfgSetIndexBits: cfg_q.set_index_bits <= cfg_data_i[CfgSetW-1:0];
        CfgOffsetBits:   cfg_q.offset_bits    <= cfg_data_i[CfgOffW-1:0];
        CfgActiveWays:   cfg_q.active_ways    <= cfg_data_i[CfgWaysW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: address split and request queue.
  slc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .push_i      (push),
    .address_i   (address_i),
    .full_o      (full),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop)
  );

  // Back end: tag memory, replacement decision and result register.
  slc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .clearing_o  (clearing),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty             = !res_valid;
  assign outcome_o         = res.outcome;
  assign way_used_o        = res.way_used;
  assign hits_total_o      = res.hits_total;
  assign misses_total_o    = res.misses_total;
  assign evictions_total_o = res.evictions_total;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the set-associative LRU tag store
// Drives addresses through the push/full port under several geometry
// settings, predicts every outcome, way and running total with an LRU model
// of its own, and checks each popped result against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import slc_pkg::*;

  localparam int ClkHigh     = 6;
  localparam int ClkLow      = 6;
  localparam int ResetCycles = 10;
  localparam int RandomItems = 1400;
  localparam int PhaseCount  = 8;
  localparam int CycleLimit  = 1000000;
  // Cycles allowed for the two-stage back end to settle before a register
  // write, and again before the verdict.
  localparam int DrainCycles = 10;
  // The long hold-off on the result side starts after this many transfers.
  localparam int HoldAfter   = 500;
  localparam int HoldCycles  = 400;
  localparam int MaxReports  = 10;
  localparam int NumLines    = NumSets * MaxWays;

  // The fourth register index decodes to nothing; writes to it must be inert.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef enum logic {ROW_LOOKUP, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [AddrW-1:0]     addr;
    logic                 pinned;
    res_t                 want;
  } dir_row_t;

  // Geometries for the random phases; the last phases pick their own at random.
  localparam cfg_t PhasePlan [6] = '{
    '{3'd1, 6'd1,  4'd8},
    '{3'd6, 6'd32, 4'd8},
    '{3'd7, 6'd0,  4'd15},
    '{3'd0, 6'd63, 4'd3},
    '{3'd5, 6'd58, 4'd6},
    '{3'd3, 6'd17, 4'd0}
  };

  // Directed sequence. The first rows run at the reset geometry (16 sets,
  // 16-byte lines, one way) where every answer is obvious, so they carry the
  // expected result as typed. The rest are checked against the LRU model.
  dir_row_t directed_rows [26] = '{
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'h0, 1'b1,
      '{OutFill,  3'd0, 32'd0, 32'd1, 32'd0}},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'h0, 1'b1,
      '{OutHit,   3'd0, 32'd1, 32'd1, 32'd0}},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{OutFill,  3'd0, 32'd1, 32'd2, 32'd0}},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'h100, 1'b1,
      '{OutEvict, 3'd0, 32'd1, 32'd3, 32'd1}},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'h00F, 1'b1,
      '{OutEvict, 3'd0, 32'd1, 32'd4, 32'd2}},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0, 64'h00F, 1'b1,
      '{OutHit,   3'd0, 32'd2, 32'd4, 32'd2}},
    // Two ways: fill both, touch the first, then the second must go.
    '{ROW_WRITE,  CfgActiveWays,   6'd2,  64'h0,   1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h020, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h120, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h020, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h220, 1'b0, '0},
    // Oversized associativity and set count are clamped; an offset of 63
    // pushes the whole tag off the top of the address.
    '{ROW_WRITE,  CfgActiveWays,   6'h3F, 64'h0, 1'b0, '0},
    '{ROW_WRITE,  CfgSetIndexBits, 6'h3F, 64'h0, 1'b0, '0},
    '{ROW_WRITE,  CfgOffsetBits,   6'd63, 64'h0, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h8000_0000_0000_0000, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h0, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    // No set bits, no offset and zero ways: one set, one way, and the two
    // top address bits fall outside the tag, so addresses alias.
    '{ROW_WRITE,  CfgSetIndexBits, 6'h38, 64'h0, 1'b0, '0},
    '{ROW_WRITE,  CfgOffsetBits,   6'd0,  64'h0, 1'b0, '0},
    '{ROW_WRITE,  CfgActiveWays,   6'h30, 64'h0, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h3FFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h4000_0000_0000_0000, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h0, 1'b0, '0},
    '{ROW_WRITE,  CfgUnused,       6'h2A, 64'h0, 1'b0, '0},
    '{ROW_LOOKUP, CfgSetIndexBits, 6'd0,  64'h5555_5555_5555_5555, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [AddrW-1:0]      address_i;
  logic                  empty;
  logic                  pop;
  logic [OutcomeW-1:0]   outcome_o;
  logic [WayOutW-1:0]    way_used_o;
  logic [TallyWidth-1:0] hits_total_o;
  logic [TallyWidth-1:0] misses_total_o;
  logic [TallyWidth-1:0] evictions_total_o;
  logic                  valid;
  logic                  ready;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  // Shadow of the tag store: geometry, lines, stamp clock and running totals.
  cfg_t                  geom;
  bit                    line_live  [NumLines];
  logic [TagWidth-1:0]   line_key   [NumLines];
  logic [StampWidth-1:0] line_age   [NumLines];
  logic [StampWidth-1:0] stamp_clock;
  logic [TallyWidth-1:0] hits_seen;
  logic [TallyWidth-1:0] misses_seen;
  logic [TallyWidth-1:0] evict_count;

  // Lookups whose results have not yet been popped, oldest first.
  res_t                  pending_lookups [$];

  // A directed row may carry its own answer; it travels with the address.
  logic                  pinned_valid;
  res_t                  pinned_res;

  int unsigned           mismatches  = 0;
  int unsigned           cycle_count = 0;

  set_assoc_lru_cache_lookup dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .address_i         (address_i),
    .empty             (empty),
    .pop               (pop),
    .outcome_o         (outcome_o),
    .way_used_o        (way_used_o),
    .hits_total_o      (hits_total_o),
    .misses_total_o    (misses_total_o),
    .evictions_total_o (evictions_total_o),
    .valid             (valid),
    .ready             (ready),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #ClkLow;
    clk_i = 1'b1;
    #ClkHigh;
  end

  // Set bits in use: anything above the maximum counts as the maximum.
  function automatic int eff_set_bits(cfg_t c);
    return (c.set_index_bits > MaxSetBits) ? MaxSetBits : int'(c.set_index_bits);
  endfunction

  // Ways in use: zero behaves as one, and the count is capped at MaxWays.
  function automatic int eff_ways(cfg_t c);
    if (c.active_ways == 0) return 1;
    return (c.active_ways > MaxWays) ? MaxWays : int'(c.active_ways);
  endfunction

  // Classifies one address against the shadow store and updates it exactly
  // as the block should: a hit refreshes the stamp, a miss takes the lowest
  // empty way or else the way with the oldest stamp (lowest way on a tie).
  function automatic res_t predict_lookup(logic [AddrW-1:0] raw);
    logic [AddrW-1:0]    a;
    logic [TagWidth-1:0] key;
    int                  sb;
    int                  ways;
    int                  base;
    int                  victim;
    bit                  hit;
    bit                  filled;
    res_t                r;
    a      = raw & AddrMask;
    sb     = eff_set_bits(geom);
    ways   = eff_ways(geom);
    base   = int'((a >> geom.offset_bits) & ((64'd1 << sb) - 64'd1)) * MaxWays;
    // A shift of 64 or more leaves nothing, so the tag is then zero.
    key    = TagWidth'(a >> (int'(geom.offset_bits) + sb));
    hit    = 1'b0;
    filled = 1'b0;
    victim = 0;
    for (int w = 0; w < ways; w++) begin
      if (!hit && line_live[base + w] && line_key[base + w] == key) begin
        hit    = 1'b1;
        victim = w;
      end
    end
    if (hit) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      if (misses_seen != '1) misses_seen++;
      for (int w = 0; w < ways; w++) begin
        if (!filled && !line_live[base + w]) begin
          filled = 1'b1;
          victim = w;
        end
      end
      if (!filled) begin
        victim = 0;
        for (int w = 1; w < ways; w++)
          if (line_age[base + w] < line_age[base + victim]) victim = w;
        if (evict_count != '1) evict_count++;
      end
      line_live[base + victim] = 1'b1;
      line_key[base + victim]  = key;
    end
    line_age[base + victim] = stamp_clock;
    stamp_clock++;
    r.outcome         = hit ? OutHit : (filled ? OutFill : OutEvict);
    r.way_used        = WayOutW'(victim);
    r.hits_total      = hits_seen;
    r.misses_total    = misses_seen;
    r.evictions_total = evict_count;
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void note_failure(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s: expected outcome %0d way %0d hits %0d misses %0d evictions %0d",
               $realtime, what, want.outcome, want.way_used, want.hits_total,
               want.misses_total, want.evictions_total);
      $display("%0t: %s:      got outcome %0d way %0d hits %0d misses %0d evictions %0d",
               $realtime, what, got.outcome, got.way_used, got.hits_total,
               got.misses_total, got.evictions_total);
    end
  endfunction

  // Offers one address after a random gap and returns once it has been
  // transferred. push is left high so that back-to-back items stay dense.
  task automatic send_lookup(logic [AddrW-1:0] addr, logic pin, res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    address_i    <= addr;
    pinned_valid <= pin;
    pinned_res   <= want;
    do @(posedge clk_i); while (full);
  endtask

  // Register writes only happen with the block idle: the address side is
  // stopped, every outstanding result has been popped and the back end has
  // had time to finish its last write-back.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    valid       <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!ready);
    valid <= 1'b0;
    case (idx)
      CfgSetIndexBits: geom.set_index_bits = data[CfgSetW-1:0];
      CfgOffsetBits:   geom.offset_bits    = data[CfgOffW-1:0];
      CfgActiveWays:   geom.active_ways    = data[CfgWaysW-1:0];
      default: ;
    endcase
  endtask

  // Every address transfer is predicted at the edge where it happens.
  always @(posedge clk_i) begin : lookup_predict
    res_t r;
    if (rst_ni && push && !full) begin
      r = predict_lookup(address_i);
      pending_lookups.push_back(pinned_valid ? pinned_res : r);
    end
  end

  // Every result transfer is compared with the oldest outstanding lookup.
  always @(posedge clk_i) begin : result_compare
    res_t want;
    res_t got;
    if (rst_ni && pop && !empty) begin
      got = '{outcome_o, way_used_o, hits_total_o, misses_total_o, evictions_total_o};
      if (pending_lookups.size() == 0) begin
        note_failure("result with no lookup outstanding", '0, got);
      end else begin
        want = pending_lookups.pop_front();
        if (got.outcome !== want.outcome || got.way_used !== want.way_used ||
            got.hits_total !== want.hits_total ||
            got.misses_total !== want.misses_total ||
            got.evictions_total !== want.evictions_total)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // Result side: random pauses between bursts of transfers, and once in the
  // run a long hold-off while the address side keeps offering, so that the
  // internal queue fills and full has to rise.
  initial begin : result_drain
    int gap;
    int burst;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    pop  <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        gap  = HoldCycles;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop  <= 1'b1;
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        do @(posedge clk_i); while (empty);
        taken++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t             c;
    int               sb;
    int               ways;
    int               pool_size;
    int               r;
    logic [TagWidth-1:0] tag_pool [10];
    int               hot_sets [4];
    logic [TagWidth-1:0] t;
    int               s;
    logic [AddrW-1:0] noise;
    logic [AddrW-1:0] addr;

    rst_ni       <= 1'b0;
    push         <= 1'b0;
    address_i    <= '0;
    valid        <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    pinned_valid <= 1'b0;
    pinned_res   <= '0;

    // Shadow state after reset: default geometry, every line empty.
    geom        = '{3'd4, 6'd4, 4'd1};
    stamp_clock = 64'd1;
    hits_seen   = '0;
    misses_seen = '0;
    evict_count = '0;
    foreach (line_live[i]) begin
      line_live[i] = 1'b0;
      line_key[i]  = '0;
      line_age[i]  = '0;
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block holds full high while it clears its valid bits after reset;
    // the first transfer simply waits for that to finish.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_lookup(directed_rows[i].addr, directed_rows[i].pinned, directed_rows[i].want);
    end

    // Random phases. Each one picks a geometry, then draws addresses mostly
    // from a small pool of tags over a few hot sets, so that sets fill up,
    // hits recur and the LRU choice is exercised; a share of the traffic
    // spreads over all sets and a tenth is raw noise. Lines left over from
    // earlier geometries stay in place and alias into the new one.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 6) begin
        c = PhasePlan[p];
      end else begin
        c.set_index_bits = CfgSetW'($urandom_range(0, 7));
        c.offset_bits    = CfgOffW'($urandom_range(0, 63));
        c.active_ways    = CfgWaysW'($urandom_range(0, 15));
      end
      // Spare data bits above each register's width are set at random.
      write_reg(CfgSetIndexBits, {CfgSetW'($urandom_range(0, 7)), c.set_index_bits});
      write_reg(CfgOffsetBits, c.offset_bits);
      write_reg(CfgActiveWays, {2'($urandom_range(0, 3)), c.active_ways});

      sb        = eff_set_bits(c);
      ways      = eff_ways(c);
      pool_size = ways + 2;
      foreach (tag_pool[i])
        tag_pool[i] = $urandom_range(0, 1) ? TagWidth'($urandom_range(0, 15))
                                           : TagWidth'({$urandom, $urandom});
      foreach (hot_sets[i])
        hot_sets[i] = $urandom_range(0, (1 << sb) - 1);

      for (int n = 0; n < RandomItems / PhaseCount; n++) begin
        r     = $urandom_range(0, 99);
        noise = {$urandom, $urandom};
        if (r < 10) begin
          addr = noise;
        end else begin
          t    = tag_pool[$urandom_range(0, pool_size - 1)];
          s    = (r < 80) ? hot_sets[$urandom_range(0, 3)]
                          : $urandom_range(0, (1 << sb) - 1);
          addr = (AddrW'(t) << (int'(c.offset_bits) + sb))
               | (AddrW'(s) << c.offset_bits)
               | (noise & ((64'd1 << c.offset_bits) - 64'd1));
        end
        send_lookup(addr, 1'b0, '0);
      end
    end

    // Wind down: stop offering, collect every outstanding result, then give
    // the back end a few more cycles so that any stray result is caught.
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_lookups.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
src/slc_pkg.sv
src/slc_front.sv
src/slc_back.sv
src/set_assoc_lru_cache_lookup.sv
tb/testbench.sv
